// File: hw/rtl/psq_pkg.sv
// Package: item types, codes and field positions for the paired-single quantizer.
package psq_pkg;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  localparam logic [2:0] QT_FLOAT = 3'd0;
  localparam logic [2:0] QT_U8    = 3'd4;
  localparam logic [2:0] QT_U16   = 3'd5;
  localparam logic [2:0] QT_S8    = 3'd6;
  localparam logic [2:0] QT_S16   = 3'd7;

  localparam int NUM_QREGS = 8;

  typedef struct packed {
    logic        opcode;
    logic [2:0]  quant_select;
    logic        single_lane;
    logic        indexed_form;
    logic        quant_enabled;
    logic [31:0] load_word0;
    logic [31:0] load_word1;
    logic [63:0] store_lane0;
    logic [63:0] store_lane1;
  } psq_in_t;

  typedef struct packed {
    logic        illegal;
    logic [63:0] result_lane0;
    logic [63:0] result_lane1;
    logic [31:0] out_word0;
    logic [31:0] out_word1;
    logic [2:0]  element_bytes;
    logic [1:0]  lanes_stored;
  } psq_out_t;

  function automatic logic [2:0] bytes_of(input logic [2:0] qtype);
    logic [2:0] b;
    case (qtype)
      QT_FLOAT:      b = 3'd4;
      QT_U8, QT_S8:  b = 3'd1;
      QT_U16, QT_S16: b = 3'd2;
      default:       b = 3'd0;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/psq_lane.sv
// One lane's load dequantize and store quantize conversions.
module psq_lane
  import psq_pkg::*;
(
  input  logic [2:0]  ld_type,
  input  logic [5:0]  ld_scale,
  input  logic [2:0]  st_type,
  input  logic [5:0]  st_scale,
  input  logic [31:0] load_word,
  input  logic [63:0] store_val,
  output logic [63:0] load_result,
  output logic [31:0] store_word
);

  // ---------------- load ----------------
  logic        l_neg;
  logic [15:0] l_mag;
  logic [4:0]  l_lz;
  logic [15:0] l_norm;
  logic signed [12:0] l_exp;
  logic [7:0]  w_e;
  logic [22:0] w_f;
  logic [4:0]  w_lz;
  logic [22:0] w_fn;
  logic        w_y;

  always_comb begin
    l_neg = 1'b0;
    l_mag = 16'd0;
    case (ld_type)
      QT_U8:  l_mag = {8'd0, load_word[7:0]};
      QT_U16: l_mag = load_word[15:0];
      QT_S8: begin
        l_neg = load_word[7];
        l_mag = l_neg ? {8'd0, 8'(-load_word[7:0])} : {8'd0, load_word[7:0]};
        if (l_neg && load_word[7:0] == 8'h80) l_mag = 16'd128;
      end
      QT_S16: begin
        l_neg = load_word[15];
        l_mag = l_neg ? 16'(-load_word[15:0]) : load_word[15:0];
      end
      default: l_mag = 16'd0;
    endcase
    l_lz = 5'd16;
    for (int i = 0; i < 16; i++) begin
      if (l_mag[i]) l_lz = 5'(15 - i);
    end
    l_norm = l_mag << l_lz[3:0];
    // value = 1.f * 2^(15-lz-scale); |scale|<=32 so always normal double
    l_exp = 13'sd1023 + 13'sd15 - 13'($unsigned(l_lz)) - 13'($signed(ld_scale));

    w_e = load_word[30:23];
    w_f = load_word[22:0];
    w_lz = 5'd23;
    for (int i = 0; i < 23; i++) begin
      if (w_f[i]) w_lz = 5'(22 - i);
    end
    w_fn = 23'(w_f << (w_lz + 5'd1));
    w_y = (w_e != 8'd0 && w_e != 8'hFF) ? ~w_e[7] : w_e[7];

    load_result = 64'd0;
    if (ld_type == QT_FLOAT) begin
      if (w_e == 8'd0 && w_f != 23'd0)
        load_result = {load_word[31], 11'(11'd896 - 11'(w_lz)), w_fn, 29'd0};
      else
        load_result = {load_word[31:30], w_y, w_y, w_y, load_word[29:0], 29'd0};
    end else if (l_mag != 16'd0) begin
      load_result = {l_neg, l_exp[10:0], l_norm[14:0], 37'd0};
    end
  end

  // ---------------- store ----------------
  logic [10:0] d_e;
  logic [51:0] d_f;
  logic        d_s;
  logic        s_nan;
  logic [24:0] r_mant;   // rounded single mantissa incl hidden bit, may carry
  logic signed [12:0] r_exp; // unbiased
  logic [23:0] sig;
  logic        s_zero;
  logic signed [12:0] ue;   // unbiased exp after scaling
  logic [40:0] ipart;
  logic [16:0] mag;
  logic [31:0] q_int;
  logic [28:0] rb;
  logic [24:0] lost;
  logic        lsb, rnd, sticky;
  logic [7:0]  sub_sh;
  logic [24:0] sub_m;

  always_comb begin
    d_s = store_val[63];
    d_e = store_val[62:52];
    d_f = store_val[51:0];
    s_nan = (d_e == 11'h7FF) && (d_f != 52'd0);
    s_zero = 1'b0;
    r_exp = 13'sd0;
    r_mant = 25'd0;
    sub_sh = 8'd0;
    sub_m = 25'd0;
    rb = 29'd0;
    lost = 25'd0;
    lsb = 1'b0; rnd = 1'b0; sticky = 1'b0;
    // round double to single (RNE), clamp to max finite
    if (d_e == 11'd0) begin
      s_zero = 1'b1;
    end else if (d_e >= 11'd1151) begin
      r_exp = 13'sd127;
      r_mant = 25'h0FFFFFF;
    end else if (d_e >= 11'd897) begin
      r_exp = 13'($signed({2'b00, d_e})) - 13'sd1023;
      lsb = d_f[29]; rnd = d_f[28]; sticky = |d_f[27:0];
      r_mant = {2'b01, d_f[51:29]} + 25'(rnd && (sticky || lsb));
      if (r_mant[24]) begin
        r_mant = r_mant >> 1;
        r_exp = r_exp + 13'sd1;
      end
      if (r_exp > 13'sd127) begin
        r_exp = 13'sd127;
        r_mant = 25'h0FFFFFF;
      end
    end else if (d_e >= 11'd872) begin
      // single denormal: keep bits at 2^-149 granularity
      sub_sh = 8'(11'd897 - d_e); // 1..25
      {sub_m, rb, lost} = {2'b01, d_f, 25'd0} >> sub_sh;
      lsb = sub_m[0]; rnd = rb[28]; sticky = (|rb[27:0]) || (|lost);
      r_mant = sub_m + 25'(rnd && (sticky || lsb));
      r_exp = -13'sd126;
      if (r_mant == 25'd0) s_zero = 1'b1;
    end else begin
      s_zero = 1'b1;
    end
    sig = r_mant[23:0];
    // scaled: value = sig * 2^(r_exp - 23 + scale); denormal sig<2^23 fine
    ue = r_exp + 13'($signed(st_scale)) - 13'sd23;
    ipart = 41'd0;
    if (!s_zero) begin
      if (ue >= 13'sd17) ipart = {41{1'b1}};
      else if (ue >= 13'sd0) ipart = 41'({17'd0, sig} << ue[4:0]);
      else if (ue > -13'sd24) ipart = 41'(sig >> 5'(-ue));
      else ipart = 41'd0;
    end
    mag = (ipart > 41'h1FFFF) ? 17'h1FFFF : ipart[16:0];
    q_int = 32'd0;
    case (st_type)
      QT_U8:  q_int = (d_s && !s_zero) ? 32'd0 : ((mag > 17'd255) ? 32'd255 : 32'(mag));
      QT_U16: q_int = (d_s && !s_zero) ? 32'd0 : ((mag > 17'd65535) ? 32'd65535 : 32'(mag));
      QT_S8:  q_int = d_s ? ((mag > 17'd128) ? 32'h80 : 32'(8'(-mag[7:0])))
                          : ((mag > 17'd127) ? 32'd127 : 32'(mag));
      QT_S16: q_int = d_s ? ((mag > 17'd32768) ? 32'h8000 : 32'(16'(-mag[15:0])))
                          : ((mag > 17'd32767) ? 32'd32767 : 32'(mag));
      default: q_int = 32'd0;
    endcase
    if (s_nan) q_int = 32'd0;
    if (st_type == QT_FLOAT)
      store_word = (d_e > 11'd896) ? {store_val[63:62], store_val[58:29]}
                                   : {store_val[63], 31'd0};
    else
      store_word = q_int;
  end

endmodule

// File: hw/rtl/paired_single_quantizer.sv
// Top level: paired-single quantized load/store conversion, one item per cycle.
//
// Usage:
//   Configuration: cfg_we writes cfg_data[31:0] into quantization register
//   cfg_index (0..7) at the clock edge; indexes 8..15 are ignored. Each register
//   holds load scale [29:24], load type [18:16], store scale [13:8] and store
//   type [2:0].
//   Command channel: an item in cmd is taken at an edge where start is high
//   and busy is low. busy is always low; an item can be taken every cycle.
//   Result channel: the converted item appears on rsp with done high for one
//   cycle, in the cycle after the item was taken (throughput 1/cycle).
//   The receiver cannot stall; each result must be taken in its cycle.
//   The conversion is combinational between the cmd inputs and the result
//   register; registers select the type and scale.
//   Reset (rst, synchronous) clears all quantization registers and done.
module paired_single_quantizer
  import psq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  psq_in_t     cmd,
  output logic        done,
  output psq_out_t    rsp,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] qregs [NUM_QREGS];
  logic [31:0] q;
  logic [2:0]  ld_type, st_type, ld_bytes, st_bytes;
  logic [63:0] ld0, ld1;
  logic [31:0] sw0, sw1;
  psq_out_t    rsp_next;

  assign busy = 1'b0;
  assign q = qregs[cmd.quant_select];
  assign ld_type = q[18:16];
  assign st_type = q[2:0];
  assign ld_bytes = bytes_of(ld_type);
  assign st_bytes = bytes_of(st_type);

  psq_lane u_lane0 (
    .ld_type(ld_type), .ld_scale(q[29:24]), .st_type(st_type), .st_scale(q[13:8]),
    .load_word(cmd.load_word0), .store_val(cmd.store_lane0),
    .load_result(ld0), .store_word(sw0)
  );

  psq_lane u_lane1 (
    .ld_type(ld_type), .ld_scale(q[29:24]), .st_type(st_type), .st_scale(q[13:8]),
    .load_word(cmd.load_word1), .store_val(cmd.store_lane1),
    .load_result(ld1), .store_word(sw1)
  );

  always_comb begin
    rsp_next = '0;
    if (!cmd.indexed_form && !cmd.quant_enabled) begin
      rsp_next.illegal = 1'b1;
    end else if (cmd.opcode == OP_LOAD) begin
      rsp_next.element_bytes = ld_bytes;
      if (ld_bytes != 3'd0) begin
        rsp_next.result_lane0 = ld0;
        rsp_next.result_lane1 = cmd.single_lane ? 64'h3FF0000000000000 : ld1;
      end
    end else begin
      rsp_next.element_bytes = st_bytes;
      if (st_bytes != 3'd0) begin
        rsp_next.out_word0 = sw0;
        rsp_next.out_word1 = cmd.single_lane ? 32'd0 : sw1;
        rsp_next.lanes_stored = cmd.single_lane ? 2'd1 : 2'd2;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
      for (int i = 0; i < NUM_QREGS; i++) qregs[i] <= 32'd0;
    end else begin
      done <= start;
      if (cfg_we && !cfg_index[3]) qregs[cfg_index[2:0]] <= cfg_data;
    end
    rsp <= rsp_next;
  end

endmodule

// File: sim/paired_single_quantizer_tb.sv
// Testbench: paired-single quantizer load/store conversion against a bit-level predictor.
`timescale 1ns / 100ps

module paired_single_quantizer_tb;
  import psq_pkg::*;

  localparam logic [2:0] QT_BAD1 = 3'd1;
  localparam logic [2:0] QT_BAD2 = 3'd2;
  localparam logic [2:0] QT_BAD3 = 3'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] DBL_QNAN = 64'h7FF8_0000_0000_0001;
  localparam logic [63:0] DBL_INF  = 64'h7FF0_0000_0000_0000;
  localparam logic [63:0] FLT_MAX_D = 64'h47EF_FFFF_E000_0000;

  class psq_scoreboard;
    bit [31:0] qreg[8];
    psq_out_t  pending_q[$];
    int        errors;
    int        loads, stores, illegals, results;

    static function real pow2(int k);
      bit [10:0] e;
      e = 11'(1023 + k);
      return $bitstoreal({1'b0, e, 52'b0});
    endfunction

    static function int scale6(bit [5:0] s);
      return s[5] ? int'(s) - 64 : int'(s);
    endfunction

    static function bit [2:0] elem_bytes(bit [2:0] t);
      case (t)
        QT_FLOAT: return 3'd4;
        QT_U8, QT_S8: return 3'd1;
        QT_U16, QT_S16: return 3'd2;
        default: return 3'd0;
      endcase
    endfunction

    static function bit [63:0] widen(bit [31:0] x);
      bit [7:0]  e;
      bit [23:0] fr;
      bit [10:0] ne;
      bit        y;
      e = x[30:23];
      fr = {1'b0, x[22:0]};
      if (e == 0 && fr != 0) begin
        ne = 11'd897;
        do begin
          fr = fr << 1;
          ne = ne - 1;
        end while (!fr[23]);
        return {x[31], ne, fr[22:0], 29'b0};
      end
      y = (e > 0 && e < 255) ? ~e[7] : e[7];
      return {x[31:30], y, y, y, x[29:0], 29'b0};
    endfunction

    static function bit [31:0] narrow(bit [63:0] x);
      if (x[62:52] > 11'd896) return {x[63:62], x[58:29]};
      return {x[63], 31'b0};
    endfunction

    static function bit [63:0] load_one(bit [31:0] w, bit [2:0] t, int s);
      int v;
      case (t)
        QT_FLOAT: return widen(w);
        QT_U8:  v = int'(w[7:0]);
        QT_U16: v = int'(w[15:0]);
        QT_S8:  v = int'($signed(w[7:0]));
        QT_S16: v = int'($signed(w[15:0]));
        default: return 64'd0;
      endcase
      return $realtobits(real'(v) * pow2(-s));
    endfunction

    static function int saturate(bit [63:0] b, int lo, int hi, int s);
      bit [62:0] mag;
      real f, c;
      mag = b[62:0];
      if (mag[62:52] == 11'h7FF && mag[51:0] != 0) return 0;
      if (mag > FLT_MAX_D[62:0]) mag = FLT_MAX_D[62:0];
      if (mag[62:52] < 11'd897) begin
        f = 0.0;
      end else begin
        if (mag[28] && (mag[29] || mag[27:0] != 0)) mag = mag + (63'd1 << 29);
        mag[28:0] = '0;
        f = $bitstoreal({b[63], mag});
      end
      c = f * pow2(s);
      if (c <= real'(lo)) return lo;
      if (c >= real'(hi)) return hi;
      return $rtoi(c);
    endfunction

    static function bit [31:0] store_one(bit [63:0] b, bit [2:0] t, int s);
      case (t)
        QT_FLOAT: return narrow(b);
        QT_U8:  return 32'(saturate(b, 0, 255, s) & 'hFF);
        QT_U16: return 32'(saturate(b, 0, 65535, s) & 'hFFFF);
        QT_S8:  return 32'(saturate(b, -128, 127, s) & 'hFF);
        QT_S16: return 32'(saturate(b, -32768, 32767, s) & 'hFFFF);
        default: return 32'd0;
      endcase
    endfunction

    function void note(psq_in_t it);
      psq_out_t r;
      bit [31:0] q;
      bit [2:0] t;
      int s;
      r = '0;
      q = qreg[it.quant_select];
      if (!it.indexed_form && !it.quant_enabled) begin
        r.illegal = 1'b1;
        illegals++;
      end else if (it.opcode == OP_LOAD) begin
        loads++;
        t = q[18:16];
        s = scale6(q[29:24]);
        r.element_bytes = elem_bytes(t);
        if (r.element_bytes != 0) begin
          r.result_lane0 = load_one(it.load_word0, t, s);
          r.result_lane1 = it.single_lane ? 64'h3FF0_0000_0000_0000
                                          : load_one(it.load_word1, t, s);
        end
      end else begin
        stores++;
        t = q[2:0];
        s = scale6(q[13:8]);
        r.element_bytes = elem_bytes(t);
        if (r.element_bytes != 0) begin
          r.out_word0 = store_one(it.store_lane0, t, s);
          if (!it.single_lane) r.out_word1 = store_one(it.store_lane1, t, s);
          r.lanes_stored = it.single_lane ? 2'd1 : 2'd2;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void field(string name, bit [63:0] exp_v, bit [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check(psq_out_t a);
      psq_out_t e;
      if (pending_q.size() == 0) begin
        $error("result with no item outstanding: %h", a);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      results++;
      field("illegal", e.illegal, a.illegal);
      field("result_lane0", e.result_lane0, a.result_lane0);
      field("result_lane1", e.result_lane1, a.result_lane1);
      field("out_word0", e.out_word0, a.out_word0);
      field("out_word1", e.out_word1, a.out_word1);
      field("element_bytes", e.element_bytes, a.element_bytes);
      field("lanes_stored", e.lanes_stored, a.lanes_stored);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  psq_in_t     cmd;
  logic        done;
  psq_out_t    rsp;
  logic        cfg_we;
  logic [3:0]  cfg_index;
  logic [31:0] cfg_data;

  psq_scoreboard sb;
  int accepted;
  int cycles;

  paired_single_quantizer dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      sb.note(cmd);
      accepted <= accepted + 1;
    end
    if (!rst && done) sb.check(rsp);
  end

  function automatic bit [31:0] qword(bit [2:0] lt, bit [5:0] ls, bit [2:0] st, bit [5:0] ss);
    bit [31:0] q;
    q = $urandom;
    q[29:24] = ls;
    q[18:16] = lt;
    q[13:8] = ss;
    q[2:0] = st;
    return q;
  endfunction

  function automatic bit [2:0] rand_type();
    case ($urandom_range(0, 5))
      0: return QT_FLOAT;
      1: return QT_U8;
      2: return QT_U16;
      3: return QT_S8;
      4: return QT_S16;
      default: return 3'($urandom);
    endcase
  endfunction

  function automatic bit [5:0] rand_scale();
    if ($urandom_range(0, 1)) return 6'($urandom);
    return 6'($urandom_range(0, 16) - 8);
  endfunction

  function automatic bit [63:0] rand_double();
    bit [63:0] b;
    int k;
    b = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: ;
      1: case ($urandom_range(0, 4))
           0: b = DBL_QNAN | {12'h800, 52'd0} & b;
           1: b = DBL_INF | (b & 64'h8000_0000_0000_0000);
           2: b = FLT_MAX_D | (b & 64'h8000_0000_0000_0000);
           3: b = b & 64'h8000_0000_0000_0000;
           default: b = b & 64'h800F_FFFF_FFFF_FFFF;
         endcase
      2: b[62:52] = 11'(1023 + $urandom_range(0, 60) - 40);
      3: begin
        k = $urandom_range(0, 140000) - 70000;
        b = $realtobits(real'(k) * psq_scoreboard::pow2($urandom_range(0, 20) - 10));
      end
      default: begin
        k = $urandom_range(0, 600) - 300;
        b = $realtobits(real'(k) + ($urandom_range(0, 1) ? 0.99999999 : -0.00000001));
      end
    endcase
    return b;
  endfunction

  task automatic write_qreg(int idx, bit [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= 4'(idx);
    cfg_data <= val;
    sb.qreg[idx] = val;
    @(negedge clk);
  endtask

  task automatic send(psq_in_t it, int gap);
    int n;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= it;
    n = accepted;
    do @(negedge clk); while (accepted == n);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic psq_in_t rand_item();
    psq_in_t it;
    logic [223:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    it = raw[$bits(psq_in_t)-1:0];
    it.quant_enabled = ($urandom_range(0, 7) != 0);
    it.store_lane0 = rand_double();
    it.store_lane1 = rand_double();
    return it;
  endfunction

  initial begin
    psq_in_t it;
    int gap_mode;
    clk = 0;
    rst = 1;
    start = 0;
    cmd = '0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_data = '0;
    accepted = 0;
    cycles = 0;
    sb = new();
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_qreg(0, qword(QT_FLOAT, 6'd0, QT_FLOAT, 6'd0));
    write_qreg(1, qword(QT_U8, 6'd0, QT_U8, 6'd0));
    write_qreg(2, qword(QT_U16, 6'h1F, QT_U16, 6'h20));
    write_qreg(3, qword(QT_S8, 6'h20, QT_S8, 6'h1F));
    write_qreg(4, qword(QT_S16, 6'h3F, QT_S16, 6'h01));
    write_qreg(5, qword(QT_BAD1, 6'd3, QT_BAD1, 6'd3));
    write_qreg(6, 32'hFFFF_FFFF);
    write_qreg(7, qword(QT_BAD3, 6'd0, QT_BAD2, 6'd0));
    cfg_we <= 1'b0;
    for (int s = 0; s < 8; s++) begin
      it = '0;
      it.quant_enabled = 1'b1;
      it.quant_select = 3'(s);
      it.opcode = OP_LOAD;
      it.load_word0 = 32'hFFFF_FFFF;
      it.load_word1 = 32'h0000_8080;
      it.single_lane = s[0];
      send(it, 0);
      it.opcode = OP_STORE;
      it.store_lane0 = s[0] ? DBL_QNAN : DBL_INF;
      it.store_lane1 = s[1] ? (DBL_INF | 64'h8000_0000_0000_0000) : FLT_MAX_D;
      send(it, 1);
    end
    it = '0;
    it.quant_enabled = 1'b1;
    it.opcode = OP_LOAD;
    it.load_word0 = 32'h0000_0001;
    it.load_word1 = 32'h7FC0_0001;
    send(it, 0);
    it.opcode = OP_STORE;
    it.store_lane0 = 64'h0000_0000_0000_0001;
    it.store_lane1 = 64'h3800_0000_0000_0000;
    send(it, 0);
    it.quant_enabled = 1'b0;
    send(it, 2);
    it.indexed_form = 1'b1;
    send(it, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < 8; r++)
        write_qreg(r, qword(rand_type(), rand_scale(), rand_type(), rand_scale()));
      cfg_we <= 1'b0;
      gap_mode = ph % 3;
      for (int i = 0; i < 200; i++) begin
        if (ph == 5 && i == 100) drain();
        send(rand_item(), gap_mode == 0 ? 0 :
             (gap_mode == 1 ? $urandom_range(0, 18) : $urandom_range(0, 2)));
      end
      drain();
    end

    repeat (4) @(negedge clk);
    $display("covered %0d loads, %0d stores, %0d illegal accesses; %0d results checked",
             sb.loads, sb.stores, sb.illegals, sb.results);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: paired_single_quantizer.f
hw/rtl/psq_pkg.sv
hw/rtl/psq_lane.sv
hw/rtl/paired_single_quantizer.sv
sim/paired_single_quantizer_tb.sv
